FILE: hdl/sphc_pkg.sv
`timescale 1ns / 1ps
// package for the stepper position and homing controller
// holds beat types, config layout, mode codes and the coil phase table; no dependencies

package sphc_pkg;

  // default widths of the tracked position and the step delay counter
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned DELAY_BITS_DEF    = 16;

  // fixed field widths
  localparam int unsigned CFG_BITS      = 16;
  localparam int unsigned TARGET_BITS   = 16;
  localparam int unsigned POS_OUT_BITS  = 24;

  // config register reset values (20 ms at 1 ms ticks, 1000 steps of travel)
  localparam logic [CFG_BITS-1:0] STEP_DELAY_RESET = 16'd20;
  localparam logic [CFG_BITS-1:0] MAX_POS_RESET    = 16'd1000;

  // position loaded when homing starts from an unknown position
  localparam int unsigned HOMING_START_POS = 4;

  // four-phase full-step pattern: bit n is coil a, bit n+4 is coil b
  localparam logic [7:0] COIL_SEQ = 8'h36;

  // config register indexes
  typedef enum logic {
    CFG_STEP_DELAY = 1'b0,
    CFG_MAX_POS    = 1'b1
  } cfg_index_t;

  // item opcodes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_t;

  // run modes of the motion sequencer
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_WAIT   = 2'd2,
    MODE_MOVING = 2'd3
  } run_mode_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] step_delay_ticks;
    logic [CFG_BITS-1:0] max_position;
  } cfg_t;

  typedef struct packed {
    logic                   opcode;
    logic [TARGET_BITS-1:0] target;
    logic                   home_switch;
  } in_item_t;

  typedef struct packed {
    logic                           coil_a;
    logic                           coil_b;
    logic                           driver_off;
    logic signed [POS_OUT_BITS-1:0] position;
    logic                           position_known;
    logic                           busy_res;
    logic                           command_rejected;
  } out_item_t;

  // coil levels {b, a} for a given phase (low two bits of the position)
  function automatic logic [1:0] phase_coils(input logic [1:0] phase);
    logic [7:0] pat;
    pat = COIL_SEQ >> phase;
    return {pat[4], pat[0]};
  endfunction

endpackage

FILE: hdl/sphc_cfg.sv
`timescale 1ns / 1ps
// configuration registers: step delay and largest target position
// depends on sphc_pkg

module sphc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [sphc_pkg::CFG_BITS-1:0]  cfg_data,
  output sphc_pkg::cfg_t                 cfg
);
  import sphc_pkg::*;

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_delay_ticks <= STEP_DELAY_RESET;
      cfg.max_position     <= MAX_POS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STEP_DELAY: cfg.step_delay_ticks <= cfg_data;
        CFG_MAX_POS:    cfg.max_position     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/sphc_core.sv
`timescale 1ns / 1ps
// motion sequencer: position, delay counter, run mode and coil state,
// updated once per item; the result reflects the state after the item. depends on sphc_pkg

module sphc_core #(
  parameter int unsigned POSITION_BITS = sphc_pkg::POSITION_BITS_DEF,
  parameter int unsigned DELAY_BITS    = sphc_pkg::DELAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sphc_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  sphc_pkg::in_item_t  item,
  output sphc_pkg::out_item_t result
);
  import sphc_pkg::*;

  // state
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic                     known, known_next;
  run_mode_t                mode, mode_next;
  logic [DELAY_BITS-1:0]    dly, dly_next;
  logic [TARGET_BITS-1:0]   goal, goal_next;
  logic                     down, down_next;
  logic [1:0]               coil, coil_next;
  logic                     drv_off, drv_off_next;

  logic                     rejected;
  logic                     do_act;
  logic                     step_now;
  logic                     finish;
  logic [TARGET_BITS-1:0]   tgt_clamped;
  logic [POSITION_BITS-1:0] tgt_ext;
  logic [POSITION_BITS-1:0] goal_ext;

  // next state: item handling, then the step/stop action
  always_comb begin
    pos_next     = pos;
    known_next   = known;
    mode_next    = mode;
    dly_next     = dly;
    goal_next    = goal;
    down_next    = down;
    coil_next    = coil;
    drv_off_next = drv_off;
    rejected     = 1'b0;
    do_act       = 1'b0;
    step_now     = 1'b0;
    finish       = 1'b0;

    tgt_clamped = (item.target > cfg.max_position) ? cfg.max_position : item.target;
    tgt_ext     = POSITION_BITS'(tgt_clamped);

    if (opcode_t'(item.opcode) == OP_TICK) begin
      if (mode != MODE_IDLE) begin
        if (dly > DELAY_BITS'(1)) begin
          dly_next = dly - DELAY_BITS'(1);
        end else begin
          dly_next = '0;
          do_act   = 1'b1;
        end
      end
    end else if (mode != MODE_IDLE) begin
      rejected = 1'b1;
    end else if (item.target == '0) begin
      // homing request
      if (!known) begin
        pos_next = POSITION_BITS'(HOMING_START_POS);
      end
      down_next    = 1'b1;
      drv_off_next = 1'b0;
      mode_next    = MODE_HOMING;
      dly_next     = '0;
      do_act       = 1'b1;
    end else if (tgt_ext != pos) begin
      goal_next    = tgt_clamped;
      down_next    = $signed(tgt_ext) < $signed(pos);
      drv_off_next = 1'b0;
      mode_next    = MODE_WAIT;
      dly_next     = DELAY_BITS'(cfg.step_delay_ticks);
    end

    goal_ext = POSITION_BITS'(goal_next);

    // action when the delay has run out
    if (do_act) begin
      unique case (mode_next)
        MODE_HOMING: begin
          if (item.home_switch || (pos_next[1:0] != 2'b00)) begin
            step_now = 1'b1;
          end else begin
            pos_next = '0;
            finish   = 1'b1;
          end
        end
        MODE_WAIT: begin
          mode_next = MODE_MOVING;
          step_now  = 1'b1;
        end
        MODE_MOVING: begin
          if (down_next && (pos_next[1:0] == 2'b00) && !item.home_switch) begin
            pos_next = '0;
            finish   = 1'b1;
          end else if (pos_next == goal_ext) begin
            finish = 1'b1;
          end else begin
            step_now = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // one full step and restart of the delay
    if (step_now) begin
      pos_next  = down_next ? (pos_next - POSITION_BITS'(1)) : (pos_next + POSITION_BITS'(1));
      coil_next = phase_coils(pos_next[1:0]);
      dly_next  = DELAY_BITS'(cfg.step_delay_ticks);
    end

    // end of move or homing
    if (finish) begin
      drv_off_next = 1'b1;
      known_next   = 1'b1;
      mode_next    = MODE_IDLE;
      dly_next     = '0;
    end
  end

  // result fields from the updated state
  always_comb begin
    result.coil_a           = coil_next[0];
    result.coil_b           = coil_next[1];
    result.driver_off       = drv_off_next;
    result.position         = POS_OUT_BITS'(pos_next);
    result.position_known   = known_next;
    result.busy_res         = (mode_next != MODE_IDLE);
    result.command_rejected = rejected;
  end

  // state registers, updated once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '1;
      known   <= 1'b0;
      mode    <= MODE_IDLE;
      dly     <= '0;
      goal    <= '0;
      down    <= 1'b0;
      coil    <= 2'b00;
      drv_off <= 1'b1;
    end else if (item_valid) begin
      pos     <= pos_next;
      known   <= known_next;
      mode    <= mode_next;
      dly     <= dly_next;
      goal    <= goal_next;
      down    <= down_next;
      coil    <= coil_next;
      drv_off <= drv_off_next;
    end
  end

  // no pending delay while idle
  assert property (@(posedge clk) disable iff (rst) (mode == MODE_IDLE) |-> (dly == '0))
    else $error("sphc_core: delay counter running while idle");

  // driver is off exactly when no move or homing runs
  assert property (@(posedge clk) disable iff (rst) drv_off == (mode == MODE_IDLE))
    else $error("sphc_core: driver state disagrees with run mode");

  // a rejected command leaves the motion state untouched
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && rejected) |=> ($stable(pos) && $stable(mode) && $stable(dly)))
    else $error("sphc_core: rejected command changed state");

  // once known, the position stays known
  assert property (@(posedge clk) disable iff (rst) !$fell(known))
    else $error("sphc_core: known flag cleared");

endmodule

FILE: hdl/stepper_position_homing_controller.sv
`timescale 1ns / 1ps
// top level of the stepper position and homing controller
// depends on sphc_pkg, sphc_cfg and sphc_core

// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one beat per time
//   tick or move command, each with a sample of the home switch. The output
//   channel (out_valid/out_ready/out_data) returns exactly one beat per input
//   beat: coil levels, driver disable, tracked position and status flags.
//   Configuration is written through cfg_we/cfg_index/cfg_data: index 0 is
//   the step delay in ticks, index 1 the largest target position. Writes take
//   effect at once and should only be made while the controller is idle.
//   Timing: an accepted beat is held in the input register; the state
//   update and the result register load happen together once the result
//   register is free. Throughput is one beat per cycle while the receiver
//   keeps up with out_ready.
//   A stalled receiver holds the result register; one more beat is still
//   taken into the input register, after which in_ready drops.
//   Reset: position -1 and unknown, idle, driver off, coils low, step delay
//   20, largest target 1000, both channel registers empty.

module stepper_position_homing_controller #(
  parameter int unsigned POSITION_BITS = sphc_pkg::POSITION_BITS_DEF,
  parameter int unsigned DELAY_BITS    = sphc_pkg::DELAY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sphc_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sphc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sphc_pkg::out_item_t           out_data
);
  import sphc_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      advance;
  out_item_t core_res;

  // handshake: the input register moves on when the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  sphc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sphc_core #(
    .POSITION_BITS (POSITION_BITS),
    .DELAY_BITS    (DELAY_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (advance),
    .item       (s1_item),
    .result     (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_res;
    end
  end

endmodule
